>>> sv/qibi_pkg.sv
package qibi_pkg;

  localparam int COORD_W_DEF = 32;
  localparam int VAL_W       = 32;
  localparam int NORM_BITS   = 29;
  localparam int MUL_W       = 33;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ACC_W       = 128;
  localparam int COEF_W      = 64;
  localparam int Q_W         = 19;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_ROOT = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

  localparam logic [1:0] TGT_A = 2'd0;
  localparam logic [1:0] TGT_B = 2'd1;
  localparam logic [1:0] TGT_C = 2'd2;

  localparam logic signed [Q_W-1:0] ONE_Q = 19'sd65536;
  localparam logic [17:0] SAT_Q = 18'd131072;

  typedef struct packed {
    logic                          req_type;
    logic [1:0]                    node_index;
    logic signed [COORD_W_DEF-1:0] coord_x;
    logic signed [COORD_W_DEF-1:0] coord_y;
    logic signed [VAL_W-1:0]       node_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] interp_value;
    logic [1:0]              status;
  } out_item_t;

  // one signed product of the shape sums per step; X terms, then Y terms
  typedef struct packed {
    logic [2:0] ia;
    logic [2:0] ib;
    logic       neg;
    logic       last;
    logic [1:0] tgt;
  } prod_op_t;

  function automatic prod_op_t prod_op(input logic [3:0] step);
    prod_op_t op;
    unique case (step)
      4'd0:  op = '{3'd3, 3'd2, 1'b0, 1'b0, TGT_A};
      4'd1:  op = '{3'd0, 3'd5, 1'b1, 1'b1, TGT_A};
      4'd2:  op = '{3'd3, 3'd1, 1'b0, 1'b0, TGT_B};
      4'd3:  op = '{3'd0, 3'd4, 1'b1, 1'b0, TGT_B};
      4'd4:  op = '{3'd6, 3'd5, 1'b0, 1'b0, TGT_B};
      4'd5:  op = '{3'd7, 3'd2, 1'b1, 1'b1, TGT_B};
      4'd6:  op = '{3'd4, 3'd6, 1'b0, 1'b0, TGT_C};
      4'd7:  op = '{3'd1, 3'd7, 1'b1, 1'b1, TGT_C};
      4'd8:  op = '{3'd4, 3'd2, 1'b0, 1'b0, TGT_A};
      4'd9:  op = '{3'd1, 3'd5, 1'b1, 1'b1, TGT_A};
      4'd10: op = '{3'd4, 3'd0, 1'b0, 1'b0, TGT_B};
      4'd11: op = '{3'd3, 3'd1, 1'b1, 1'b0, TGT_B};
      4'd12: op = '{3'd6, 3'd5, 1'b0, 1'b0, TGT_B};
      4'd13: op = '{3'd7, 3'd2, 1'b1, 1'b1, TGT_B};
      4'd14: op = '{3'd3, 3'd6, 1'b0, 1'b0, TGT_C};
      4'd15: op = '{3'd0, 3'd7, 1'b1, 1'b1, TGT_C};
      default: op = '{3'd0, 3'd0, 1'b0, 1'b0, TGT_A};
    endcase
    return op;
  endfunction

  function automatic logic in_square(input logic signed [Q_W-1:0] v);
    return (v >= -ONE_Q) && (v <= ONE_Q);
  endfunction

endpackage

>>> sv/quad_inverse_bilinear_interp.sv
// channel | ports   | handshake
// --------+---------+----------------------------------
// input   | in_req  | taken when start && !busy
// result  | out_res | out_valid, one cycle, no stall
//
// A load item writes one corner when it is taken; busy stays low.
// A query item keeps busy high until its result is shown, including up to COORD_WIDTH-27
// normalize shifts: one 33x33 multiplier, one 64-step square root and
// one 17-step divider are shared over both axes.
// Reset (rst_n low, synchronous) returns to idle; corner stores are not cleared.
// The receiver cannot stall: a result is shown for one cycle, and the next
// item may be taken in that same cycle.
module quad_inverse_bilinear_interp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  qibi_pkg::in_item_t            in_req,
  output logic                          out_valid,
  output qibi_pkg::out_item_t           out_res
);

  localparam int COORD_WIDTH = qibi_pkg::COORD_W_DEF;
  localparam int VW = (COORD_WIDTH + 4 > 30) ? COORD_WIDTH + 4 : 30;
  localparam int NB = qibi_pkg::NORM_BITS;
  localparam int MW = qibi_pkg::MUL_W;
  localparam int PW = qibi_pkg::PROD_W;
  localparam int AW = qibi_pkg::ACC_W;
  localparam int CW = qibi_pkg::COEF_W;
  localparam int QW = qibi_pkg::Q_W;

  localparam logic signed [MW-1:0] ONE_M   = 33'sd65536;
  localparam logic signed [AW-1:0] RND     = 128'sh200000000;
  localparam logic signed [AW-1:0] I32_MAX = 128'sh7FFFFFFF;
  localparam logic signed [AW-1:0] I32_MIN = -128'sh80000000;

  typedef enum logic [4:0] {
    S_IDLE, S_SUMS, S_NORM, S_CMUL, S_CACC, S_SOLVE, S_DMUL, S_DACC, S_DCHK,
    S_SQRT, S_TSET, S_DIV, S_DDONE, S_AXIS, S_BMUL, S_BACC, S_BFIN
  } state_t;

  typedef enum logic [1:0] {DS_FINAL, DS_R1, DS_R2} dsel_t;

  state_t                          state_r;
  logic                            out_valid_r;
  qibi_pkg::out_item_t             out_res_r;
  logic signed [COORD_WIDTH-1:0]   cx_r [4];
  logic signed [COORD_WIDTH-1:0]   cy_r [4];
  logic signed [31:0]              cv_r [4];
  logic signed [COORD_WIDTH-1:0]   qx_r, qy_r;
  logic [VW-1:0]                   vmag_r [8];
  logic                            vneg_r [8];
  logic signed [NB:0]              nv_r [8];
  logic [3:0]                      step_r;
  logic signed [AW-1:0]            acc_r;
  logic signed [PW-1:0]            prod_r;
  logic signed [CW-1:0]            ca_r, cb_r, cc_r;
  logic                            axis_r;
  logic [2:0]                      dstep_r;
  logic [AW-1:0]                   rad_r;
  logic [67:0]                     srem_r;
  logic [63:0]                     sroot_r;
  logic [5:0]                      scnt_r;
  logic [63:0]                     tmag_r;
  logic                            tneg_r;
  logic [65:0]                     un_r, ud_r;
  logic [67:0]                     drem_r;
  logic [17:0]                     dq_r;
  logic                            dneg_r;
  logic [4:0]                      dcnt_r;
  dsel_t                           dsel_r;
  logic signed [QW-1:0]            r1_r, x_r;
  logic [1:0]                      k_r, bsub_r;
  logic [34:0]                     w_r;

  logic signed [VW-1:0]  ex [4];
  logic signed [VW-1:0]  ey [4];
  logic signed [VW-1:0]  qxe, qye, sx, sy;
  logic signed [VW-1:0]  v [8];
  logic [VW-1:0]         vm [8];
  logic [VW-1:0]         norm_or;
  logic                  norm_big;
  qibi_pkg::prod_op_t    op;
  logic [63:0]           ma, mb, mc, pa, pb, tm;
  logic signed [MW-1:0]  mop_a, mop_b, xe, ye, cval;
  logic signed [PW-1:0]  prod_nxt;
  logic signed [AW-1:0]  prod_ext, dterm, dacc_sum, cacc_sum, bsum, bres;
  logic [6:0]            dsh;
  logic                  dsub;
  logic [67:0]           srem_sh, strial;
  logic                  sge;
  logic                  div_go;
  dsel_t                 div_sel;
  logic [65:0]           dv_num, dv_den;
  logic                  dv_num_neg, dv_den_neg;
  logic                  dsat, dge;
  logic [67:0]           dr_sh, dr_new;
  logic [17:0]           dq_new;
  logic signed [QW-1:0]  dres, rlo, rhi;
  logic                  accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ex[k] = {{(VW-COORD_WIDTH){cx_r[k][COORD_WIDTH-1]}}, cx_r[k]};
      ey[k] = {{(VW-COORD_WIDTH){cy_r[k][COORD_WIDTH-1]}}, cy_r[k]};
    end
    qxe  = {{(VW-COORD_WIDTH){qx_r[COORD_WIDTH-1]}}, qx_r};
    qye  = {{(VW-COORD_WIDTH){qy_r[COORD_WIDTH-1]}}, qy_r};
    sx   = ex[0] + ex[1] + ex[2] + ex[3];
    sy   = ey[0] + ey[1] + ey[2] + ey[3];
    v[0] = -ex[0] + ex[1] + ex[2] - ex[3];
    v[1] = -ex[0] - ex[1] + ex[2] + ex[3];
    v[2] =  ex[0] - ex[1] + ex[2] - ex[3];
    v[3] = -ey[0] + ey[1] + ey[2] - ey[3];
    v[4] = -ey[0] - ey[1] + ey[2] + ey[3];
    v[5] =  ey[0] - ey[1] + ey[2] - ey[3];
    v[6] = (qxe <<< 2) - sx;
    v[7] = (qye <<< 2) - sy;
    norm_or = '0;
    for (int k = 0; k < 8; k++) begin
      vm[k]   = v[k][VW-1] ? VW'(-v[k]) : VW'(v[k]);
      norm_or = norm_or | vmag_r[k];
    end
    norm_big = |norm_or[VW-1:NB];
  end

  always_comb begin
    op = qibi_pkg::prod_op(step_r);
    ma = ca_r[CW-1] ? 64'(-ca_r) : 64'(ca_r);
    mb = cb_r[CW-1] ? 64'(-cb_r) : 64'(cb_r);
    mc = cc_r[CW-1] ? 64'(-cc_r) : 64'(cc_r);
    pa = dstep_r[2] ? ma : mb;
    pb = dstep_r[2] ? mc : mb;
    tm = mb + sroot_r;
    xe = {{(MW-QW){x_r[QW-1]}}, x_r};
    ye = {{(MW-QW){r1_r[QW-1]}}, r1_r};
    cval = {cv_r[k_r][31], cv_r[k_r]};
    mop_a = '0;
    mop_b = '0;
    unique case (state_r)
      S_CMUL: begin
        mop_a = {{(MW-NB-1){nv_r[op.ia][NB]}}, nv_r[op.ia]};
        mop_b = {{(MW-NB-1){nv_r[op.ib][NB]}}, nv_r[op.ib]};
      end
      S_DMUL: begin
        mop_a = {1'b0, dstep_r[1] ? pa[63:32] : pa[31:0]};
        mop_b = {1'b0, dstep_r[0] ? pb[63:32] : pb[31:0]};
      end
      S_BMUL: begin
        unique case (bsub_r)
          2'd0: begin
            mop_a = (k_r == 2'd1 || k_r == 2'd2) ? ONE_M + xe : ONE_M - xe;
            mop_b = k_r[1] ? ONE_M + ye : ONE_M - ye;
          end
          2'd1: begin
            mop_a = {1'b0, w_r[31:0]};
            mop_b = cval;
          end
          default: begin
            mop_a = {30'b0, w_r[34:32]};
            mop_b = cval;
          end
        endcase
      end
      default: begin
        mop_a = '0;
        mop_b = '0;
      end
    endcase
    prod_nxt = mop_a * mop_b;
  end

  always_comb begin
    prod_ext = {{(AW-PW){prod_r[PW-1]}}, prod_r};
    unique case (dstep_r[1:0])
      2'd0:    dsh = 7'd0;
      2'd3:    dsh = 7'd64;
      default: dsh = 7'd32;
    endcase
    if (dstep_r[2]) dsh = dsh + 7'd2;
    dterm    = prod_ext <<< dsh;
    dsub     = dstep_r[2] && !(cc_r == '0 || (ca_r[CW-1] != cc_r[CW-1]));
    dacc_sum = dsub ? acc_r - dterm : acc_r + dterm;
    cacc_sum = op.neg ? acc_r - prod_ext : acc_r + prod_ext;
    bsum     = acc_r + RND;
    bres     = bsum >>> 34;
    srem_sh  = {srem_r[65:0], rad_r[AW-1:AW-2]};
    strial   = {2'b0, sroot_r, 2'b01};
    sge      = (srem_sh >= strial);
  end

  always_comb begin
    div_go     = 1'b0;
    div_sel    = DS_FINAL;
    dv_num     = {2'b0, mc};
    dv_num_neg = !cc_r[CW-1];
    dv_den     = {2'b0, mb};
    dv_den_neg = cb_r[CW-1];
    unique case (state_r)
      S_SOLVE: div_go = (ca_r == '0) && (cb_r != '0);
      S_DCHK: begin
        div_go     = !acc_r[AW-1] && (acc_r == '0);
        dv_num     = {2'b0, mb};
        dv_num_neg = !cb_r[CW-1];
        dv_den     = {1'b0, ma, 1'b0};
        dv_den_neg = ca_r[CW-1];
      end
      S_TSET: begin
        div_go     = 1'b1;
        div_sel    = DS_R1;
        dv_num     = {2'b0, tm};
        dv_num_neg = !cb_r[CW-1];
        dv_den     = {1'b0, ma, 1'b0};
        dv_den_neg = ca_r[CW-1];
      end
      S_DDONE: begin
        div_go     = (dsel_r == DS_R1);
        div_sel    = DS_R2;
        dv_num     = {1'b0, mc, 1'b0};
        dv_num_neg = cc_r[CW-1];
        dv_den     = {2'b0, tmag_r};
        dv_den_neg = tneg_r;
      end
      default: div_go = 1'b0;
    endcase
  end

  always_comb begin
    dsat   = ({2'b0, un_r} >= {1'b0, ud_r, 1'b0});
    dr_sh  = (dcnt_r == '0) ? drem_r : {drem_r[66:0], 1'b0};
    dge    = (dr_sh >= {2'b0, ud_r});
    dr_new = dge ? dr_sh - {2'b0, ud_r} : dr_sh;
    dq_new = {dq_r[16:0], dge};
    dres   = dneg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
    rlo    = (r1_r < dres) ? r1_r : dres;
    rhi    = (r1_r < dres) ? dres : r1_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_req.req_type == qibi_pkg::REQ_LOAD) begin
              cx_r[in_req.node_index] <= in_req.coord_x;
              cy_r[in_req.node_index] <= in_req.coord_y;
              cv_r[in_req.node_index] <= in_req.node_value;
            end else begin
              qx_r    <= in_req.coord_x;
              qy_r    <= in_req.coord_y;
              state_r <= S_SUMS;
            end
          end
        end
        S_SUMS: begin
          for (int k = 0; k < 8; k++) begin
            vmag_r[k] <= vm[k];
            vneg_r[k] <= v[k][VW-1];
          end
          state_r <= S_NORM;
        end
        S_NORM: begin
          if (norm_big) begin
            for (int k = 0; k < 8; k++) vmag_r[k] <= vmag_r[k] >> 1;
          end else begin
            for (int k = 0; k < 8; k++) begin
              nv_r[k] <= vneg_r[k] ? -$signed({1'b0, vmag_r[k][NB-1:0]})
                                   : $signed({1'b0, vmag_r[k][NB-1:0]});
            end
            step_r  <= '0;
            acc_r   <= '0;
            axis_r  <= 1'b0;
            state_r <= S_CMUL;
          end
        end
        S_CMUL: state_r <= S_CACC;
        S_CACC: begin
          if (op.last) begin
            acc_r <= '0;
            unique case (op.tgt)
              qibi_pkg::TGT_A: ca_r <= cacc_sum[CW-1:0];
              qibi_pkg::TGT_B: cb_r <= cacc_sum[CW-1:0];
              default:         cc_r <= cacc_sum[CW-1:0];
            endcase
          end else begin
            acc_r <= cacc_sum;
          end
          step_r  <= step_r + 4'd1;
          state_r <= (step_r[2:0] == 3'd7) ? S_SOLVE : S_CMUL;
        end
        S_SOLVE: begin
          if (ca_r == '0) begin
            if (cb_r == '0) begin
              out_valid_r <= 1'b1;
              out_res_r   <= '{interp_value: '0, status: qibi_pkg::STATUS_NO_ROOT};
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_DIV;
            end
          end else begin
            acc_r   <= '0;
            dstep_r <= '0;
            state_r <= S_DMUL;
          end
        end
        S_DMUL: state_r <= S_DACC;
        S_DACC: begin
          acc_r   <= dacc_sum;
          dstep_r <= dstep_r + 3'd1;
          state_r <= (dstep_r == 3'd7) ? S_DCHK : S_DMUL;
        end
        S_DCHK: begin
          if (acc_r[AW-1]) begin
            out_valid_r <= 1'b1;
            out_res_r   <= '{interp_value: '0, status: qibi_pkg::STATUS_NO_ROOT};
            state_r     <= S_IDLE;
          end else if (acc_r == '0) begin
            state_r <= S_DIV;
          end else begin
            rad_r   <= acc_r;
            srem_r  <= '0;
            sroot_r <= '0;
            scnt_r  <= '0;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          srem_r  <= sge ? srem_sh - strial : srem_sh;
          sroot_r <= {sroot_r[62:0], sge};
          rad_r   <= rad_r << 2;
          scnt_r  <= scnt_r + 6'd1;
          if (scnt_r == 6'd63) state_r <= S_TSET;
        end
        S_TSET: begin
          tmag_r  <= tm;
          tneg_r  <= !cb_r[CW-1];
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (dcnt_r == '0 && dsat) begin
            dq_r    <= qibi_pkg::SAT_Q;
            state_r <= S_DDONE;
          end else begin
            drem_r <= dr_new;
            dq_r   <= dq_new;
            dcnt_r <= dcnt_r + 5'd1;
            if (dcnt_r == 5'd16) state_r <= S_DDONE;
          end
        end
        S_DDONE: begin
          unique case (dsel_r)
            DS_R1: begin
              r1_r    <= dres;
              state_r <= S_DIV;
            end
            DS_R2: begin
              r1_r    <= qibi_pkg::in_square(rlo) ? rlo : rhi;
              state_r <= S_AXIS;
            end
            default: begin
              r1_r    <= dres;
              state_r <= S_AXIS;
            end
          endcase
        end
        S_AXIS: begin
          if (!axis_r) begin
            x_r     <= r1_r;
            axis_r  <= 1'b1;
            step_r  <= 4'd8;
            acc_r   <= '0;
            state_r <= S_CMUL;
          end else if (!qibi_pkg::in_square(x_r) || !qibi_pkg::in_square(r1_r)) begin
            out_valid_r <= 1'b1;
            out_res_r   <= '{interp_value: '0, status: qibi_pkg::STATUS_OUTSIDE};
            state_r     <= S_IDLE;
          end else begin
            k_r     <= '0;
            bsub_r  <= '0;
            acc_r   <= '0;
            state_r <= S_BMUL;
          end
        end
        S_BMUL: state_r <= S_BACC;
        S_BACC: begin
          unique case (bsub_r)
            2'd0:    w_r   <= prod_r[34:0];
            2'd1:    acc_r <= acc_r + prod_ext;
            default: acc_r <= acc_r + (prod_ext <<< 32);
          endcase
          if (bsub_r == 2'd2) begin
            bsub_r <= '0;
            k_r    <= k_r + 2'd1;
            state_r <= (k_r == 2'd3) ? S_BFIN : S_BMUL;
          end else begin
            bsub_r  <= bsub_r + 2'd1;
            state_r <= S_BMUL;
          end
        end
        S_BFIN: begin
          out_valid_r <= 1'b1;
          out_res_r.status <= qibi_pkg::STATUS_OK;
          priority if (bres > I32_MAX) out_res_r.interp_value <= I32_MAX[31:0];
          else if (bres < I32_MIN)     out_res_r.interp_value <= I32_MIN[31:0];
          else                         out_res_r.interp_value <= bres[31:0];
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (div_go) begin
        un_r   <= dv_num;
        ud_r   <= dv_den;
        drem_r <= {2'b0, dv_num};
        dneg_r <= dv_num_neg ^ dv_den_neg;
        dq_r   <= '0;
        dcnt_r <= '0;
        dsel_r <= div_sel;
      end
    end
  end

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != qibi_pkg::STATUS_OK) |-> out_res.interp_value == '0)
    else $error("failed item carries a nonzero value");

  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.req_type == qibi_pkg::REQ_LOAD) |=> (!busy && !out_valid))
    else $error("load item stalled or gave a result");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.req_type == qibi_pkg::REQ_QUERY) |=> busy)
    else $error("query item did not start");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int STALL_LIMIT = 5000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  qibi_pkg::in_item_t   in_req = '0;
  logic                 out_valid;
  qibi_pkg::out_item_t  out_res;

  qibi_pkg::in_item_t  pend[$];
  qibi_pkg::out_item_t expected_results[$];
  qibi_pkg::in_item_t  cur;
  longint    corner_x[4] = '{default: 0};
  longint    corner_y[4] = '{default: 0};
  longint    corner_v[4] = '{default: 0};
  int        n_items = 0, n_queries = 0, n_loads = 0, n_errors = 0;
  int        n_ok = 0, n_noroot = 0, n_outside = 0;
  int        gap = 0, stall = 0;
  bit        no_idle = 1'b0;

  quad_inverse_bilinear_interp uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic bit in_sq(longint v);
    return v >= -65536 && v <= 65536;
  endfunction

  function automatic longint qdiv_sat(longint n, longint d);
    longint unsigned un, ud, q, r;
    bit neg;
    un = mag(n);
    ud = mag(d);
    neg = (n < 0) != (d < 0);
    if (un >= 2 * ud) begin
      q = 131072;
    end else begin
      q = un / ud;
      r = un % ud;
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          r = r - ud;
          q = q | 1;
        end
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned isqrt(logic [127:0] v);
    longint unsigned r, cand;
    r = 0;
    for (int i = 61; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      if (128'(cand) * 128'(cand) <= v) r = cand;
    end
    return r;
  endfunction

  function automatic bit solve_root(longint a, longint b, longint c, output longint root);
    logic [127:0] bb, ac4, disc;
    longint unsigned s;
    longint t, r1, r2, lo, hi;
    root = 0;
    if (a == 0) begin
      if (b == 0) return 1'b0;
      root = qdiv_sat(-c, b);
      return 1'b1;
    end
    bb = 128'(mag(b)) * 128'(mag(b));
    ac4 = 128'(4 * mag(a)) * 128'(mag(c));
    if (c == 0 || (a < 0) != (c < 0)) begin
      disc = bb + ac4;
    end else begin
      if (bb < ac4) return 1'b0;
      disc = bb - ac4;
    end
    if (disc == 0) begin
      root = qdiv_sat(-b, 2 * a);
      return 1'b1;
    end
    s = isqrt(disc);
    t = (b >= 0) ? -(b + longint'(s)) : -(b - longint'(s));
    r1 = qdiv_sat(t, 2 * a);
    r2 = qdiv_sat(2 * c, t);
    lo = r1 < r2 ? r1 : r2;
    hi = r1 < r2 ? r2 : r1;
    root = in_sq(lo) ? lo : hi;
    return 1'b1;
  endfunction

  function automatic qibi_pkg::out_item_t predict_interp(logic signed [31:0] px,
                                                         logic signed [31:0] py);
    longint v[8];
    longint qx, qy, X, Y;
    longint w[4];
    longint unsigned m;
    int sh;
    logic signed [99:0] acc;
    qibi_pkg::out_item_t o;
    qx = px;
    qy = py;
    v[0] = -corner_x[0] + corner_x[1] + corner_x[2] - corner_x[3];
    v[1] = -corner_x[0] - corner_x[1] + corner_x[2] + corner_x[3];
    v[2] = corner_x[0] - corner_x[1] + corner_x[2] - corner_x[3];
    v[3] = -corner_y[0] + corner_y[1] + corner_y[2] - corner_y[3];
    v[4] = -corner_y[0] - corner_y[1] + corner_y[2] + corner_y[3];
    v[5] = corner_y[0] - corner_y[1] + corner_y[2] - corner_y[3];
    v[6] = 4 * qx - (corner_x[0] + corner_x[1] + corner_x[2] + corner_x[3]);
    v[7] = 4 * qy - (corner_y[0] + corner_y[1] + corner_y[2] + corner_y[3]);
    m = 0;
    for (int k = 0; k < 8; k++) m = m | mag(v[k]);
    sh = 0;
    while ((m >> sh) >= (64'd1 << 29)) sh++;
    for (int k = 0; k < 8; k++)
      v[k] = v[k] < 0 ? -longint'(mag(v[k]) >> sh) : longint'(mag(v[k]) >> sh);
    o.status = qibi_pkg::STATUS_OK;
    o.interp_value = '0;
    X = 0;
    Y = 0;
    if (!solve_root(v[3] * v[2] - v[0] * v[5],
                    v[3] * v[1] - v[0] * v[4] + v[6] * v[5] - v[7] * v[2],
                    v[4] * v[6] - v[1] * v[7], X) ||
        !solve_root(v[4] * v[2] - v[1] * v[5],
                    v[4] * v[0] - v[3] * v[1] + v[6] * v[5] - v[7] * v[2],
                    v[3] * v[6] - v[0] * v[7], Y)) begin
      o.status = qibi_pkg::STATUS_NO_ROOT;
    end else if (!in_sq(X) || !in_sq(Y)) begin
      o.status = qibi_pkg::STATUS_OUTSIDE;
    end
    if (o.status == qibi_pkg::STATUS_OK) begin
      w[0] = (65536 - X) * (65536 - Y);
      w[1] = (65536 + X) * (65536 - Y);
      w[2] = (65536 + X) * (65536 + Y);
      w[3] = (65536 - X) * (65536 + Y);
      acc = 0;
      for (int k = 0; k < 4; k++) acc = acc + w[k] * corner_v[k];
      acc = acc + (100'sd1 <<< 33);
      acc = acc >>> 34;
      if (acc > 100'sd2147483647) acc = 100'sd2147483647;
      if (acc < -100'sd2147483648) acc = -100'sd2147483648;
      o.interp_value = acc[31:0];
    end
    return o;
  endfunction

  task automatic add_load(int idx, longint x, longint y, longint val);
    qibi_pkg::in_item_t s;
    s.req_type = qibi_pkg::REQ_LOAD;
    s.node_index = idx[1:0];
    s.node_value = val[31:0];
    s.coord_x = x[31:0];
    s.coord_y = y[31:0];
    pend.push_back(s);
    n_items++;
  endtask

  task automatic add_query(longint x, longint y);
    qibi_pkg::in_item_t s;
    s.req_type = qibi_pkg::REQ_QUERY;
    s.node_index = 2'($urandom_range(0, 3));
    s.node_value = $urandom;
    s.coord_x = x[31:0];
    s.coord_y = y[31:0];
    pend.push_back(s);
    n_items++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (cur.req_type == qibi_pkg::REQ_LOAD) begin
          corner_x[cur.node_index] = cur.coord_x;
          corner_y[cur.node_index] = cur.coord_y;
          corner_v[cur.node_index] = cur.node_value;
          n_loads++;
        end else begin
          expected_results.push_back(predict_interp(cur.coord_x, cur.coord_y));
          n_queries++;
        end
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        gap = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (!start || !busy) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (pend.size() > 0) begin
          cur = pend.pop_front();
          in_req <= cur;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    qibi_pkg::out_item_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result expected=none actual value=%h status=%0d", $time,
                 out_res.interp_value, out_res.status);
        n_errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_res.status != exp_r.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                   exp_r.status, out_res.status);
          n_errors++;
        end
        if (out_res.interp_value != exp_r.interp_value) begin
          $display("%0t: interp_value mismatch expected=%h actual=%h", $time,
                   exp_r.interp_value, out_res.interp_value);
          n_errors++;
        end
        case (exp_r.status)
          qibi_pkg::STATUS_OK:      n_ok++;
          qibi_pkg::STATUS_NO_ROOT: n_noroot++;
          default:                  n_outside++;
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    longint cx, cy, sc, jit, val;
    longint kx[4], ky[4];
    int r, nq;
    kx = '{-1, 1, 1, -1};
    ky = '{-1, -1, 1, 1};

    // unit square, values 0..3
    for (int k = 0; k < 4; k++) add_load(k, kx[k] * 65536, ky[k] * 65536, k * 65536);
    add_query(0, 0);
    add_query(65536, 65536);
    add_query(-65536, -65536);
    add_query(131072, 0);
    add_query(32768, -16384);
    // value extremes
    for (int k = 0; k < 4; k++) add_load(k, kx[k] * 65536, ky[k] * 65536, 64'sh7fffffff);
    add_query(19660, 19660);
    for (int k = 0; k < 4; k++) add_load(k, kx[k] * 65536, ky[k] * 65536, -64'sh80000000);
    add_query(-19660, 40000);
    // collapsed quad: no root
    for (int k = 0; k < 4; k++) add_load(k, 12345, -6789, k);
    add_query(12345, -6789);
    // coordinate extremes
    for (int k = 0; k < 4; k++)
      add_load(k, kx[k] < 0 ? -64'sh80000000 : 64'sh7fffffff,
               ky[k] < 0 ? -64'sh80000000 : 64'sh7fffffff, $signed($urandom));
    add_query(0, 0);
    add_query(64'sh7fffffff, -64'sh80000000);

    while (n_items < 750) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        sc = 64'd1 << $urandom_range(8, 24);
        cx = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
        cy = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
        for (int k = 0; k < 4; k++) begin
          if (r == 7 && k != $urandom_range(0, 3)) continue;
          jit = sc / 2;
          val = $urandom_range(0, 1) ? longint'($signed($urandom))
                                     : longint'($urandom_range(0, 1 << 20)) - (1 << 19);
          add_load(k, cx + kx[k] * sc + longint'($urandom_range(0, jit)) - jit / 2,
                   cy + ky[k] * sc + longint'($urandom_range(0, jit)) - jit / 2, val);
        end
        nq = $urandom_range(1, 6);
        for (int i = 0; i < nq; i++)
          add_query(cx + longint'($urandom_range(0, 3 * sc)) - 3 * sc / 2,
                    cy + longint'($urandom_range(0, 3 * sc)) - 3 * sc / 2);
      end else if (r == 8) begin
        add_load($urandom_range(0, 3), $signed($urandom), $signed($urandom), $signed($urandom));
        add_query($signed($urandom), $signed($urandom));
      end else begin
        add_query($signed($urandom), $signed($urandom));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (pend.size() > 0 || start) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Sent %0d items: %0d corner loads, %0d queries.", n_items, n_loads, n_queries);
    $display("Results: %0d inside, %0d without root, %0d outside the square.",
             n_ok, n_noroot, n_outside);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
